// File: rtl/core/fixed_point_alu_assert.svh
// Assertion macros used by the port-level checker file of the fixed-point ALU.
// Depends on nothing; the user must have clk and arst_n in scope.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fpa_pkg.sv
// Types and constants of the fixed-point ALU.
// Used by every module and interface of the block; depends on nothing.
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
		OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_FROM_INT, OP_TO_INT
	} fpa_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} fpa_status_t;

	localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

	// Width of the division remainder: holds |a| shifted by up to 30 fraction bits.
	localparam int REM_W = 62;
	// Quotient bits produced by the divider chain, one per cell.
	localparam int QUO_W = 33;

	typedef struct packed {
		logic                 valid;
		fpa_op_t              opcode;
		logic signed [31:0]   simple_val;
		fpa_status_t          simple_st;
		logic signed [63:0]   prod;
		logic                 neg;
		logic                 ovf;
		logic [REM_W-1:0]     rem;
		logic [31:0]          den;
		logic [QUO_W-1:0]     quo;
	} fpa_item_t;

endpackage

// File: rtl/core/fpa_req_if.sv
// Request channel of the fixed-point ALU: opcode and two operands.
// Depends on fpa_pkg.
interface fpa_req_if;
	import fpa_pkg::*;

	logic               valid;
	logic               ready;
	fpa_op_t            opcode;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source(output valid, output opcode, output operand_a, output operand_b,
		input ready);
	modport sink(input valid, input opcode, input operand_a, input operand_b,
		output ready);
endinterface

// File: rtl/core/fpa_rsp_if.sv
// Response channel of the fixed-point ALU: result value and status.
// Depends on fpa_pkg.
interface fpa_rsp_if;
	import fpa_pkg::*;

	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	fpa_status_t        status_code;

	modport source(output valid, output result_value, output status_code, input ready);
	modport sink(input valid, input result_value, input status_code, output ready);
endinterface

// File: rtl/core/fpa_front.sv
// First pipeline stage: the simple operations, the multiplier and divider setup.
// Depends on fpa_pkg.
module fpa_front #(
	parameter int FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid,
	input  fpa_pkg::fpa_op_t    opcode,
	input  logic signed [31:0]  operand_a,
	input  logic signed [31:0]  operand_b,
	output fpa_pkg::fpa_item_t  item_s1
);
	import fpa_pkg::*;

	fpa_item_t          d;
	logic signed [32:0] sum;
	logic signed [32:0] dif;
	logic signed [32:0] inc;
	logic signed [32:0] dec;
	logic signed [63:0] shl;
	logic [31:0]        mag_a;
	logic [REM_W-1:0]   num;
	logic               gt;
	logic               lt;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] == v[31])
			return v[31:0];
		return v[32] ? MIN32 : MAX32;
	endfunction

	always_comb begin
		sum   = 33'(operand_a) + 33'(operand_b);
		dif   = 33'(operand_a) - 33'(operand_b);
		inc   = 33'(operand_a) + 33'sd1;
		dec   = 33'(operand_a) - 33'sd1;
		shl   = 64'(operand_a) <<< FRAC_BITS;
		gt    = operand_a > operand_b;
		lt    = operand_a < operand_b;
		mag_a = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
		num   = REM_W'(mag_a) << FRAC_BITS;

		d            = '0;
		d.valid      = valid;
		d.opcode     = opcode;
		d.simple_st  = ST_OK;
		d.prod       = 64'(operand_a) * 64'(operand_b);
		d.neg        = operand_a[31] ^ operand_b[31];
		d.den        = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);
		d.rem        = num;
		// A quotient of 2^33 or more saturates whatever its sign.
		d.ovf        = (num >> QUO_W) >= REM_W'(d.den);

		case (opcode)
			OP_ADD: begin
				d.simple_val = sat33(sum);
				d.simple_st  = (sum[32] != sum[31]) ? ST_OVF : ST_OK;
			end
			OP_SUB: begin
				d.simple_val = sat33(dif);
				d.simple_st  = (dif[32] != dif[31]) ? ST_OVF : ST_OK;
			end
			OP_DIV: begin
				d.simple_val = operand_a[31] ? MIN32 : MAX32;
				d.simple_st  = (operand_b == 32'sd0) ? ST_DIVZ : ST_OK;
			end
			OP_GT:  d.simple_val = 32'(gt);
			OP_LT:  d.simple_val = 32'(lt);
			OP_GE:  d.simple_val = 32'(!lt);
			OP_LE:  d.simple_val = 32'(!gt);
			OP_EQ:  d.simple_val = 32'(operand_a == operand_b);
			OP_NE:  d.simple_val = 32'(operand_a != operand_b);
			OP_MIN: d.simple_val = lt ? operand_a : operand_b;
			OP_MAX: d.simple_val = gt ? operand_a : operand_b;
			OP_INC: begin
				d.simple_val = sat33(inc);
				d.simple_st  = (inc[32] != inc[31]) ? ST_OVF : ST_OK;
			end
			OP_DEC: begin
				d.simple_val = sat33(dec);
				d.simple_st  = (dec[32] != dec[31]) ? ST_OVF : ST_OK;
			end
			OP_FROM_INT: begin
				if (shl[63:31] == '0 || shl[63:31] == '1) begin
					d.simple_val = shl[31:0];
				end else begin
					d.simple_val = operand_a[31] ? MIN32 : MAX32;
					d.simple_st  = ST_OVF;
				end
			end
			OP_TO_INT: d.simple_val = operand_a >>> FRAC_BITS;
			default: d.simple_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1.valid <= 1'b0;
		end else if (en) begin
			item_s1 <= d;
		end
	end
endmodule

// File: rtl/core/fpa_div_cell.sv
// One restoring-division cell: decides a single quotient bit and passes the item on.
// Depends on fpa_pkg.
module fpa_div_cell #(
	parameter int SHIFT = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  fpa_pkg::fpa_item_t item_in,
	output fpa_pkg::fpa_item_t item_q
);
	import fpa_pkg::*;

	fpa_item_t d;

	always_comb begin
		d = item_in;
		if ((item_in.rem >> SHIFT) >= REM_W'(item_in.den)) begin
			d.rem        = item_in.rem - (REM_W'(item_in.den) << SHIFT);
			d.quo[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q.valid <= 1'b0;
		end else if (en) begin
			item_q <= d;
		end
	end
endmodule

// File: rtl/core/fpa_back.sv
// Last stage: rounds and saturates multiply and divide, selects and registers the result.
// Depends on fpa_pkg.
module fpa_back #(
	parameter int FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  fpa_pkg::fpa_item_t  item_in,
	output logic                valid_q,
	output logic signed [31:0]  value_q,
	output fpa_pkg::fpa_status_t status_q
);
	import fpa_pkg::*;

	logic [63:0]         mag_p;
	logic [63:0]         m;
	logic                mneg;
	logic [QUO_W:0]      q;
	logic                rnd;
	logic signed [31:0]  val;
	fpa_status_t         st;

	always_comb begin
		mneg  = item_in.prod[63];
		mag_p = mneg ? 64'(-item_in.prod) : 64'(item_in.prod);
		m     = (mag_p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		rnd   = {item_in.rem[32:0], 1'b0} >= 34'(item_in.den);
		q     = (QUO_W+1)'(item_in.quo) + (QUO_W+1)'(rnd);

		val = item_in.simple_val;
		st  = item_in.simple_st;
		case (item_in.opcode)
			OP_MUL: begin
				if (mneg ? (m > 64'h8000_0000) : (m > 64'h7FFF_FFFF)) begin
					val = mneg ? MIN32 : MAX32;
					st  = ST_OVF;
				end else begin
					val = mneg ? 32'(-m) : m[31:0];
				end
			end
			OP_DIV: begin
				if (item_in.simple_st == ST_OK) begin
					if (item_in.ovf || (item_in.neg ? (q > 34'h0_8000_0000)
						: (q > 34'h0_7FFF_FFFF))) begin
						val = item_in.neg ? MIN32 : MAX32;
						st  = ST_OVF;
					end else begin
						val = item_in.neg ? 32'(-q) : q[31:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q  <= item_in.valid;
			value_q  <= val;
			status_q <= st;
		end
	end
endmodule

// File: rtl/core/fixed_point_alu.sv
// Fixed-point ALU: one operand stage, 33 divider cells, one output stage.
// Throughput is one transaction per cycle while the output is not stalled; the chain of divider cells sets the latency.
// The whole pipeline advances together and holds only while a result waits at the output.
// Reset (arst_n low) clears every stage's valid bit; payload registers are not reset.
// Depends on fpa_pkg, fpa_req_if, fpa_rsp_if, fpa_front, fpa_div_cell and fpa_back.
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);
	import fpa_pkg::*;

	// The pipeline moves whenever the output register is empty or being drained.
	// Every operation walks the same path, so results leave in request order.
	logic      en;
	fpa_item_t chain [QUO_W+1];

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// Add, compare, conversion and the like finish here; multiply forms its full
	// product, and divide forms |a| << FRAC_BITS, |b| and its early overflow check.
	fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (req.valid),
		.opcode    (req.opcode),
		.operand_a (req.operand_a),
		.operand_b (req.operand_b),
		.item_s1   (chain[0])
	);

	// Restoring divider: each cell settles one quotient bit, most significant first,
	// and hands the partial remainder to its neighbor through its output register.
	for (genvar k = 0; k < QUO_W; k++) begin : g_cell
		fpa_div_cell #(.SHIFT(QUO_W - 1 - k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.item_in (chain[k]),
			.item_q  (chain[k+1])
		);
	end

	// Rounding to nearest with ties away from zero, saturation and result selection.
	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.item_in  (chain[QUO_W]),
		.valid_q  (rsp.valid),
		.value_q  (rsp.result_value),
		.status_q (rsp.status_code)
	);
endmodule

// File: rtl/core/fpa_checker.sv
// Port-level checks on the result channel of the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu_assert.svh.
`include "fixed_point_alu_assert.svh"

module fpa_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 valid,
	input logic                 ready,
	input logic signed [31:0]   result_value,
	input fpa_pkg::fpa_status_t status_code
);
	import fpa_pkg::*;

	`FPA_ASSERT_NEXT(a_rsp_hold, valid && !ready, valid && $stable(result_value) && $stable(status_code), "result changed while stalled")
	`FPA_ASSERT_NOW(a_ovf_sat, valid && status_code == ST_OVF, result_value == MAX32 || result_value == MIN32, "overflow without saturated value")
	`FPA_ASSERT_NOW(a_divz_sat, valid && status_code == ST_DIVZ, result_value == MAX32 || result_value == MIN32, "division by zero without saturated value")
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (rsp.valid),
	.ready        (rsp.ready),
	.result_value (rsp.result_value),
	.status_code  (rsp.status_code)
);

// File: tb/sv/fpa_alu_checker.sv
`timescale 1ns / 100ps
// Checker for the fixed-point ALU: watches both channels, predicts results, compares.
// Depends on fpa_pkg, fpa_req_if and fpa_rsp_if.
module fpa_alu_checker #(
	parameter int FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	fpa_req_if   req,
	fpa_rsp_if   rsp,
	output int   fail_count,
	output int   pending
);
	import fpa_pkg::*;

	typedef struct {
		logic signed [31:0] value;
		fpa_status_t        status;
	} alu_answer_t;

	alu_answer_t expected_answers[$];

	// Saturates a wide value to the 32-bit signed range.
	function automatic alu_answer_t saturate(input longint v, input fpa_status_t st);
		alu_answer_t ans;
		ans.status = st;
		if (v > longint'(MAX32)) begin
			ans.value = MAX32;
			ans.status = ST_OVF;
		end else if (v < longint'(MIN32)) begin
			ans.value = MIN32;
			ans.status = ST_OVF;
		end else begin
			ans.value = v[31:0];
		end
		return ans;
	endfunction

	function automatic alu_answer_t alu_answer(input fpa_op_t op,
		input logic signed [31:0] a32, input logic signed [31:0] b32);
		longint a, b, p;
		longint unsigned m, num, den, q;
		alu_answer_t ans;
		a = a32;
		b = b32;
		ans.value = '0;
		ans.status = ST_OK;
		case (op)
			OP_ADD: ans = saturate(a + b, ST_OK);
			OP_SUB: ans = saturate(a - b, ST_OK);
			OP_MUL: begin
				p = a * b;
				m = (p < 0) ? -p : p;
				m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				ans = saturate((p < 0) ? -longint'(m) : longint'(m), ST_OK);
			end
			OP_DIV: begin
				if (b == 0) begin
					ans.status = ST_DIVZ;
					ans.value = (a >= 0) ? MAX32 : MIN32;
				end else begin
					num = ((a < 0) ? -a : a);
					num = num << FRAC_BITS;
					den = (b < 0) ? -b : b;
					q = (2 * num + den) / (2 * den);
					if (q > (64'd1 << 32))
						q = 64'd1 << 32;
					ans = saturate(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), ST_OK);
				end
			end
			OP_GT: ans.value = (a > b);
			OP_LT: ans.value = (a < b);
			OP_GE: ans.value = (a >= b);
			OP_LE: ans.value = (a <= b);
			OP_EQ: ans.value = (a == b);
			OP_NE: ans.value = (a != b);
			OP_MIN: ans.value = (a < b) ? a32 : b32;
			OP_MAX: ans.value = (a > b) ? a32 : b32;
			OP_INC: ans = saturate(a + 1, ST_OK);
			OP_DEC: ans = saturate(a - 1, ST_OK);
			OP_FROM_INT: ans = saturate(a * (longint'(1) << FRAC_BITS), ST_OK);
			default: ans.value = a32 >>> FRAC_BITS;
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk) begin
		alu_answer_t want;
		if (arst_n) begin
			if (req.valid && req.ready)
				expected_answers.push_back(alu_answer(req.opcode, req.operand_a,
					req.operand_b));
			if (rsp.valid && rsp.ready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch("result with no transaction outstanding");
				end else begin
					want = expected_answers.pop_front();
					if (rsp.result_value !== want.value)
						report_mismatch($sformatf("value %h, expected %h",
							rsp.result_value, want.value));
					if (rsp.status_code !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp.status_code, want.status));
				end
			end
			pending = expected_answers.size();
		end
	end
endmodule

// File: tb/sv/tb_fixed_point_alu.sv
`timescale 1ns / 100ps
// Top of the fixed-point ALU testbench: clock, reset, stimulus and verdict.
// Depends on fpa_pkg, both channel interfaces, fixed_point_alu and fpa_alu_checker.
module tb_fixed_point_alu;
	import fpa_pkg::*;

	localparam int FRAC_BITS = 8;
	// The pipeline is 35 stages deep; wait a bit longer than that at the end.
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;

	fpa_req_if req();
	fpa_rsp_if rsp();

	fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	fpa_alu_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Every input is known from time zero.
	initial begin
		req.valid = 1'b0;
		req.opcode = OP_ADD;
		req.operand_a = '0;
		req.operand_b = '0;
		rsp.ready = 1'b0;
	end

	// The receiver cycles through stall patterns: always ready, random, and
	// mostly stalled. Each pattern lasts a random stretch so that back-pressure
	// lands on every stage of the pipeline.
	int stall_mode = 0;
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(10, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= $urandom_range(0, 1);
			default: rsp.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	int burst_left = 0;

	// Presents one transaction and holds it until the ALU takes it. Ready is
	// sampled at the falling edge, where it is settled for the coming rising edge.
	// Between most bursts the sender goes quiet for a random stretch.
	task automatic send_op(input fpa_op_t op, input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.opcode <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		do begin
			@(negedge clk);
			taken = req.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Operands are drawn from several pools so that multiply and divide see
	// moderate magnitudes as well as the full range and its extremes.
	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8191)) - 4096;
			2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			3: begin
				case ($urandom_range(0, 4))
					0: return MAX32;
					1: return MIN32;
					2: return 32'sd0;
					3: return 32'sd1;
					default: return -32'sd1;
				endcase
			end
			4: return $signed($urandom_range(0, 15)) - 8;
			default: return $signed($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	initial begin
		logic signed [31:0] a, b;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the extremes, every operation, overflow on each
		// saturating operation, division by zero with each dividend sign,
		// equal operands for min and max, and to-int on negative values.
		send_op(OP_ADD, MAX32, 32'sd1);
		send_op(OP_SUB, MIN32, 32'sd1);
		send_op(OP_MUL, MAX32, MAX32);
		send_op(OP_MUL, MIN32, MAX32);
		send_op(OP_MUL, 32'sd384, -32'sd128);
		send_op(OP_DIV, 32'sd256, 32'sd0);
		send_op(OP_DIV, 32'sd0, 32'sd0);
		send_op(OP_DIV, -32'sd5, 32'sd0);
		send_op(OP_DIV, MIN32, 32'sd1);
		send_op(OP_DIV, MIN32, -32'sd1);
		send_op(OP_DIV, 32'sd1, -32'sd512);
		send_op(OP_GT, MIN32, MAX32);
		send_op(OP_LT, MIN32, MAX32);
		send_op(OP_GE, 32'sd7, 32'sd7);
		send_op(OP_LE, MAX32, MIN32);
		send_op(OP_EQ, -32'sd1, -32'sd1);
		send_op(OP_NE, 32'sd0, MIN32);
		send_op(OP_MIN, 32'sd42, 32'sd42);
		send_op(OP_MAX, MIN32, MIN32);
		send_op(OP_INC, MAX32, 32'sd0);
		send_op(OP_DEC, MIN32, 32'sd0);
		send_op(OP_FROM_INT, 32'sh0080_0000, 32'sd0);
		send_op(OP_FROM_INT, -32'sd3, MAX32);
		send_op(OP_TO_INT, -32'sd1, 32'sd0);
		send_op(OP_TO_INT, MIN32, -32'sd1);

		// Random part.
		repeat (400) begin
			a = pick_operand();
			b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
			send_op(fpa_op_t'($urandom_range(0, 15)), a, b);
		end
		req.valid <= 1'b0;

		// Let the checker record the last transaction before counting what is left.
		@(negedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/fpa_pkg.sv
rtl/core/fpa_req_if.sv
rtl/core/fpa_rsp_if.sv
rtl/core/fpa_front.sv
rtl/core/fpa_div_cell.sv
rtl/core/fpa_back.sv
rtl/core/fixed_point_alu.sv
rtl/core/fpa_checker.sv
tb/sv/fpa_alu_checker.sv
tb/sv/tb_fixed_point_alu.sv
